>>> hw/rtl/mhpq_pkg.sv
package mhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = ADDR_W + 2;
	localparam int KEY_W    = 32;
	localparam int OCC_W    = 7;

	typedef logic signed [KEY_W-1:0] key_t;

	localparam key_t EMPTY_KEY = '1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

>>> hw/rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue of signed 32-bit keys, up to 64 entries. Raise start with
// mode and key while busy is low; every transfer yields exactly one result, shown for one
// cycle with done high, and the result cannot be held off by the receiver. An enqueue on a
// full queue or a dequeue on an empty one reports in the cycle after the transfer. An
// enqueue compares the new key with each parent in turn on its way up; a dequeue
// compares the moved key with the children of each node on its way down. The single
// read port of the heap memory is read once per parent and once per child. The next
// transfer may start in the cycle in which done is high.
module max_heap_priority_queue
	import mhpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             mode,
	input  key_t             key,
	output logic             done,
	output key_t             out_key,
	output logic [1:0]       status,
	output logic [OCC_W-1:0] occupancy
);

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_ENQ_RD    = 10'b00_0000_0010,
		S_ENQ_CMP   = 10'b00_0000_0100,
		S_ENQ_WR    = 10'b00_0000_1000,
		S_DEQ_ROOT  = 10'b00_0001_0000,
		S_DEQ_RLAST = 10'b00_0010_0000,
		S_DEQ_LAST  = 10'b00_0100_0000,
		S_DN_RD_L   = 10'b00_1000_0000,
		S_DN_RD_R   = 10'b01_0000_0000,
		S_DN_CMP_R  = 10'b10_0000_0000
	} state_t;

	key_t mem [CAPACITY];

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] pos_q;
	key_t              key_q;
	key_t              rd_q;
	key_t              left_q;
	logic              done_q;
	key_t              out_key_q;
	status_t           status_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	key_t              mem_wd;
	logic [ADDR_W-1:0] mem_ra;

	logic [ADDR_W-1:0] pos_m1;
	logic [ADDR_W-1:0] parent;
	logic [IDX_W-1:0]  l_idx;
	logic [IDX_W-1:0]  r_idx;
	logic              has_l;
	logic              has_r;
	logic              accept;
	logic              full;
	logic              right_wins;
	key_t              best_val;
	logic [ADDR_W-1:0] best_idx;

	assign accept = start && (state_q == S_IDLE);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign pos_m1 = pos_q - ADDR_W'(1);
	assign parent = pos_m1 >> 1;
	assign l_idx  = (IDX_W'(pos_q) << 1) + IDX_W'(1);
	assign r_idx  = l_idx + IDX_W'(1);
	assign has_l  = l_idx < IDX_W'(count_q);
	assign has_r  = r_idx < IDX_W'(count_q);

	// The right child only wins when strictly greater, so ties keep the left child.
	assign right_wins = rd_q > left_q;
	assign best_val   = right_wins ? rd_q : left_q;
	assign best_idx   = right_wins ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_q;
		mem_wd = key_q;
		mem_ra = '0;
		unique case (state_q)
			S_ENQ_RD: begin
				mem_ra = parent;
			end
			S_ENQ_CMP: begin
				mem_we = 1'b1;
				mem_wd = (key_q > rd_q) ? rd_q : key_q;
			end
			S_ENQ_WR: begin
				mem_we = 1'b1;
			end
			S_DEQ_RLAST: begin
				mem_ra = count_q[ADDR_W-1:0];
			end
			S_DN_RD_L: begin
				mem_ra = l_idx[ADDR_W-1:0];
				mem_we = !has_l;
			end
			S_DN_RD_R: begin
				mem_ra = r_idx[ADDR_W-1:0];
				mem_we = !has_r;
				mem_wd = (rd_q > key_q) ? rd_q : key_q;
			end
			S_DN_CMP_R: begin
				mem_we = 1'b1;
				mem_wd = (best_val > key_q) ? best_val : key_q;
			end
			default: begin
				mem_ra = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_DONE;
			out_key_q <= '0;
			pos_q     <= '0;
			key_q     <= '0;
			left_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q     <= key;
						out_key_q <= '0;
						status_q  <= ST_DONE;
						pos_q     <= '0;
						if (!mode) begin
							if (full) begin
								status_q <= ST_FULL;
								done_q   <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
								pos_q   <= count_q[ADDR_W-1:0];
								state_q <= (count_q == '0) ? S_ENQ_WR : S_ENQ_RD;
							end
						end else begin
							if (count_q == '0) begin
								out_key_q <= EMPTY_KEY;
								status_q  <= ST_EMPTY;
								done_q    <= 1'b1;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= S_DEQ_ROOT;
							end
						end
					end
				end
				S_ENQ_RD: begin
					state_q <= S_ENQ_CMP;
				end
				S_ENQ_CMP: begin
					if (key_q > rd_q) begin
						pos_q   <= parent;
						state_q <= (parent == '0) ? S_ENQ_WR : S_ENQ_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_ENQ_WR: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DEQ_ROOT: begin
					state_q <= S_DEQ_RLAST;
				end
				S_DEQ_RLAST: begin
					out_key_q <= rd_q;
					if (count_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DEQ_LAST;
					end
				end
				S_DEQ_LAST: begin
					key_q   <= rd_q;
					state_q <= S_DN_RD_L;
				end
				S_DN_RD_L: begin
					if (has_l) begin
						state_q <= S_DN_RD_R;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DN_RD_R: begin
					left_q <= rd_q;
					if (has_r) begin
						state_q <= S_DN_CMP_R;
					end else if (rd_q > key_q) begin
						pos_q   <= l_idx[ADDR_W-1:0];
						state_q <= S_DN_RD_L;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DN_CMP_R: begin
					if (best_val > key_q) begin
						pos_q   <= best_idx;
						state_q <= S_DN_RD_L;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign out_key   = out_key_q;
	assign status    = status_q;
	assign occupancy = OCC_W'(count_q);

endmodule

>>> hw/rtl/mhpq_checker.sv
module mhpq_checker
	import mhpq_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             mode,
	input key_t             key,
	input logic             done,
	input key_t             out_key,
	input logic [1:0]       status,
	input logic [OCC_W-1:0] occupancy
);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result shown while the queue is still busy.");

	a_transfer_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("Accepted transfer neither started work nor produced a result.");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("Queue became busy without a transfer.");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EMPTY |-> out_key == EMPTY_KEY && occupancy == '0)
		else $error("Empty dequeue result is malformed.");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> out_key == '0 && occupancy == OCC_W'(CAPACITY))
		else $error("Dropped enqueue result is malformed.");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);
